>>> rtl/core/swv_pkg.sv
// ----------------------------------------------------------------------------
// Streaming Welford variance package
// Shared widths, defaults and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package swv_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int VARIANCE_WIDTH  = 47;
   localparam int COUNT_BITS      = 13;
   localparam int SUM_BITS        = 64;
   localparam int STEP_BITS       = $clog2(SUM_BITS + 1);

   localparam int DEF_MAX_COUNT   = 4096;
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_FRAC_BITS   = 16;

   typedef struct packed {
      logic load;
      logic mark_overflow;
      logic start_mean_div;
      logic update_mean;
      logic calc_dev;
      logic mult;
      logic accumulate;
      logic start_var_div;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic count_full;
      logic last;
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage

>>> rtl/core/swv_req_if.sv
// ----------------------------------------------------------------------------
// Sample request channel
// Valid/ready channel carrying one sample and its end-of-set mark.
// ----------------------------------------------------------------------------
interface swv_req_if;

   logic                                    valid;
   logic                                    ready;
   logic signed [swv_pkg::SAMPLE_WIDTH-1:0] sample_value;
   logic                                    last_sample;

   modport source (output valid, output sample_value, output last_sample, input ready);
   modport sink   (input valid, input sample_value, input last_sample, output ready);

endinterface

>>> rtl/core/swv_rsp_if.sv
// ----------------------------------------------------------------------------
// Variance response channel
// Valid/ready channel carrying the variance, the count and the overflow mark.
// ----------------------------------------------------------------------------
interface swv_rsp_if;

   logic                               valid;
   logic                               ready;
   logic [swv_pkg::VARIANCE_WIDTH-1:0] variance_q16;
   logic [swv_pkg::COUNT_BITS-1:0]     sample_count;
   logic                               count_overflow;

   modport source (output valid, output variance_q16, output sample_count,
                   output count_overflow, input ready);
   modport sink   (input valid, input variance_q16, input sample_count,
                   input count_overflow, output ready);

endinterface

>>> rtl/core/swv_divider.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle. The dividend is loaded left-aligned,
// so a run of a given number of steps divides the top bits of the word.
// ----------------------------------------------------------------------------
module swv_divider #(
   parameter int DIVIDEND_BITS = swv_pkg::SUM_BITS,
   parameter int DIVISOR_BITS  = swv_pkg::COUNT_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic [DIVIDEND_BITS-1:0]                 dividend,
   input  logic [DIVISOR_BITS-1:0]                  divisor,
   input  logic [$clog2(DIVIDEND_BITS+1)-1:0]       steps,
   output logic [DIVIDEND_BITS-1:0]                 quotient,
   output logic                                     done
);

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  dsr_ff, dsr_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS:0]    trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      trial   = shifted - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIVISOR_BITS]) begin
            rem_in = trial[DIVISOR_BITS-1:0];
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_BITS-1:0];
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

>>> rtl/core/swv_datapath.sv
// ----------------------------------------------------------------------------
// Welford datapath
// Holds the running mean, the deviation square sum, the count and the
// response register, and carries out the steps the controller commands.
// ----------------------------------------------------------------------------
module swv_datapath #(
   parameter int MAX_COUNT   = swv_pkg::DEF_MAX_COUNT,
   parameter int SAMPLE_BITS = swv_pkg::DEF_SAMPLE_BITS,
   parameter int FRAC_BITS   = swv_pkg::DEF_FRAC_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  swv_pkg::cmd_type                        cmd,
   output swv_pkg::status_type                     status,
   input  logic signed [swv_pkg::SAMPLE_WIDTH-1:0] sample_value,
   input  logic                                    last_sample,
   input  logic                                    rsp_ready,
   output logic                                    rsp_valid,
   output logic [swv_pkg::VARIANCE_WIDTH-1:0]      variance_q16,
   output logic [swv_pkg::COUNT_BITS-1:0]          sample_count,
   output logic                                    count_overflow
);

   localparam int MAG_BITS  = SAMPLE_BITS + FRAC_BITS;
   localparam int MEAN_BITS = MAG_BITS + 2;
   localparam int SUM_BITS  = swv_pkg::SUM_BITS;
   localparam int CNT_BITS  = swv_pkg::COUNT_BITS;
   localparam int STP_BITS  = swv_pkg::STEP_BITS;
   localparam int VAR_BITS  = swv_pkg::VARIANCE_WIDTH;

   logic signed [MEAN_BITS-1:0] x_ff, x_in;
   logic                        last_ff;
   logic signed [MEAN_BITS-1:0] mean_ff, mean_in;
   logic [SUM_BITS-1:0]         sum_ff, sum_in;
   logic [CNT_BITS-1:0]         seen_ff, seen_in;
   logic                        ovf_ff, ovf_in;
   logic [MAG_BITS-1:0]         dold_ff;
   logic                        dold_neg_ff;
   logic [MAG_BITS-1:0]         dnew_ff;
   logic [2*MAG_BITS-1:0]       prod_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [VAR_BITS-1:0]         var_ff;
   logic [CNT_BITS-1:0]         cnt_out_ff;
   logic                        ovf_out_ff;

   logic signed [SAMPLE_BITS-1:0] sample_low;
   logic signed [MEAN_BITS-1:0]   diff;
   logic [MAG_BITS-1:0]           diff_mag;
   logic signed [MEAN_BITS-1:0]   mean_step;
   logic                          div_start;
   logic [SUM_BITS-1:0]           div_dividend;
   logic [CNT_BITS-1:0]           div_divisor;
   logic [STP_BITS-1:0]           div_steps;
   logic [SUM_BITS-1:0]           div_quotient;
   logic                          div_done;

   swv_divider #(
      .DIVIDEND_BITS (SUM_BITS),
      .DIVISOR_BITS  (CNT_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .quotient (div_quotient),
      .done     (div_done)
   );

   always_comb begin
      sample_low = sample_value[SAMPLE_BITS-1:0];
      x_in       = {{(MEAN_BITS-MAG_BITS){sample_low[SAMPLE_BITS-1]}}, sample_low,
                    {FRAC_BITS{1'b0}}};
      diff       = x_ff - mean_ff;
      diff_mag   = diff[MEAN_BITS-1] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
      mean_step  = dold_neg_ff ? -MEAN_BITS'(div_quotient[MAG_BITS-1:0])
                               :  MEAN_BITS'(div_quotient[MAG_BITS-1:0]);

      div_start = cmd.start_mean_div | cmd.start_var_div;
      if (cmd.start_mean_div) begin
         div_dividend = {diff_mag, {(SUM_BITS-MAG_BITS){1'b0}}};
         div_divisor  = seen_ff + CNT_BITS'(1);
         div_steps    = STP_BITS'(MAG_BITS);
      end else begin
         div_dividend = sum_ff;
         div_divisor  = seen_ff;
         div_steps    = STP_BITS'(SUM_BITS);
      end

      mean_in = mean_ff;
      sum_in  = sum_ff;
      seen_in = seen_ff;
      ovf_in  = ovf_ff;
      if (cmd.mark_overflow) begin
         ovf_in = 1'b1;
      end
      if (cmd.update_mean) begin
         mean_in = mean_ff + mean_step;
         seen_in = seen_ff + CNT_BITS'(1);
      end
      if (cmd.accumulate) begin
         sum_in = sum_ff + SUM_BITS'(prod_ff >> FRAC_BITS);
      end
      if (cmd.emit) begin
         mean_in = '0;
         sum_in  = '0;
         seen_in = '0;
         ovf_in  = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= x_in;
         last_ff <= last_sample;
      end
      if (cmd.start_mean_div) begin
         dold_ff     <= diff_mag;
         dold_neg_ff <= diff[MEAN_BITS-1];
      end
      if (cmd.calc_dev) begin
         dnew_ff <= diff_mag;
      end
      if (cmd.mult) begin
         prod_ff <= dold_ff * dnew_ff;
      end
      if (cmd.emit) begin
         var_ff     <= (seen_ff == '0) ? '0 : div_quotient[VAR_BITS-1:0];
         cnt_out_ff <= seen_ff;
         ovf_out_ff <= ovf_ff;
      end
      if (reset) begin
         mean_ff      <= '0;
         sum_ff       <= '0;
         seen_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mean_ff      <= mean_in;
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      status.count_full = (seen_ff == CNT_BITS'(MAX_COUNT));
      status.last       = last_ff;
      status.div_done   = div_done;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign variance_q16   = var_ff;
   assign sample_count   = cnt_out_ff;
   assign count_overflow = ovf_out_ff;

endmodule

>>> rtl/core/swv_controller.sv
// ----------------------------------------------------------------------------
// Welford controller
// Sequences each request through the mean division, the deviation product and
// the accumulation, or marks overflow if full; a variance division ends a set.
// ----------------------------------------------------------------------------
module swv_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  swv_pkg::status_type status,
   output swv_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_MEAN_DIV,
      S_DEV,
      S_MULT,
      S_ACC,
      S_VAR_START,
      S_VAR_DIV,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (status.count_full) begin
               cmd.mark_overflow = 1'b1;
               state_in = status.last ? S_VAR_START : S_IDLE;
            end else begin
               cmd.start_mean_div = 1'b1;
               state_in = S_MEAN_DIV;
            end
         end
         S_MEAN_DIV: begin
            if (status.div_done) begin
               cmd.update_mean = 1'b1;
               state_in = S_DEV;
            end
         end
         S_DEV: begin
            cmd.calc_dev = 1'b1;
            state_in = S_MULT;
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.accumulate = 1'b1;
            state_in = status.last ? S_VAR_START : S_IDLE;
         end
         S_VAR_START: begin
            cmd.start_var_div = 1'b1;
            state_in = S_VAR_DIV;
         end
         S_VAR_DIV: begin
            if (status.div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/streaming_welford_variance.sv
// A sample below the full count runs through the setup, the bit-serial mean division,
// the deviation, the product and the accumulation before the next request is taken.
// A last sample adds the 64-step variance division before the response.
// A response waits in its own register while the next request is already being taken.
// Reset clears the mean, the sum, the count, the overflow mark and the response valid.
// ----------------------------------------------------------------------------
// Streaming Welford variance
// Population variance of signed sample sets in fixed point, by Welford's rule.
// ----------------------------------------------------------------------------
module streaming_welford_variance #(
   parameter int MAX_COUNT   = swv_pkg::DEF_MAX_COUNT,
   parameter int SAMPLE_BITS = swv_pkg::DEF_SAMPLE_BITS,
   parameter int FRAC_BITS   = swv_pkg::DEF_FRAC_BITS
) (
   input  logic     clock,
   input  logic     reset,
   swv_req_if.sink  req_chan,
   swv_rsp_if.source rsp_chan
);

   swv_pkg::cmd_type    cmd;
   swv_pkg::status_type status;

   swv_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   swv_datapath #(
      .MAX_COUNT   (MAX_COUNT),
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .sample_value   (req_chan.sample_value),
      .last_sample    (req_chan.last_sample),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .variance_q16   (rsp_chan.variance_q16),
      .sample_count   (rsp_chan.sample_count),
      .count_overflow (rsp_chan.count_overflow)
   );

endmodule
